// ===== src/mmdcc_pkg.sv =====
`default_nettype none

package mmdcc_pkg;

	// sizes
	localparam int NOTE_DEPTH_DEF  = 256;
	localparam int EVENT_DEPTH_DEF = 16;
	localparam int CHANNELS        = 16;
	localparam int CTL_ENTRIES     = 2048;
	localparam int CTL_AW          = $clog2(CTL_ENTRIES);
	localparam int CFG_DW          = 7;

	// register indexes
	localparam logic [1:0] REG_ENCODER_MODE    = 2'd0;
	localparam logic [1:0] REG_BEATS_PER_BAR   = 2'd1;
	localparam logic [1:0] REG_CLOCKS_PER_BEAT = 2'd2;

	// encoder modes
	localparam logic [1:0] MODE_ABSOLUTE   = 2'd0;
	localparam logic [1:0] MODE_REL_OFFSET = 2'd1;
	localparam logic [1:0] MODE_REL_INCDEC = 2'd2;

	// message types (status high nibble)
	localparam logic [3:0] TYPE_NOTE_OFF    = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON     = 4'h9;
	localparam logic [3:0] TYPE_CTL_CHANGE  = 4'hB;
	localparam logic [3:0] TYPE_PROG_CHANGE = 4'hC;
	localparam logic [3:0] TYPE_SYSTEM      = 4'hF;

	// system codes (status low nibble)
	localparam logic [3:0] SYS_CLOCK = 4'h8;
	localparam logic [3:0] SYS_START = 4'hA;

	// message lengths
	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	// relative encoder constants
	localparam logic [6:0] DEC_CODE   = 7'd97;
	localparam logic [6:0] REL_CENTER = 7'd64;

	// position limits
	localparam logic [5:0] MAX_BEATS = 6'd32;

	typedef enum logic [2:0] {
		FUNC_MESSAGE   = 3'd0,
		FUNC_READ_CTL  = 3'd1,
		FUNC_READ_PROG = 3'd2,
		FUNC_POP_NOTE  = 3'd3,
		FUNC_POP_EVENT = 3'd4
	} func_t;

	typedef struct packed {
		logic       note_on;
		logic [3:0] channel;
		logic [6:0] number;
		logic [6:0] velocity;
	} note_entry_t;

	typedef struct packed {
		logic [3:0] channel;
		logic [6:0] number;
		logic [7:0] value;
	} event_entry_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  read_value;
		logic [3:0]  out_channel;
		logic [6:0]  out_number;
		logic [6:0]  out_velocity;
		logic        out_note_on;
		logic [15:0] bar_count;
		logic [4:0]  beat_count;
		logic [6:0]  pulse_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== src/mmdcc_if.sv =====
`default_nettype none

// request channel
interface mmdcc_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] status_byte;
	logic [6:0] data_one;
	logic [6:0] data_two;
	logic [1:0] msg_len;
	logic [3:0] query_channel;
	logic [6:0] query_controller;

	modport source (
		output valid, func, status_byte, data_one, data_two, msg_len,
			query_channel, query_controller,
		input ready
	);
	modport sink (
		input valid, func, status_byte, data_one, data_two, msg_len,
			query_channel, query_controller,
		output ready
	);
endinterface

// result channel
interface mmdcc_out_if;
	logic              valid;
	logic              ready;
	logic              found;
	logic signed [7:0] read_value;
	logic [3:0]        out_channel;
	logic [6:0]        out_number;
	logic [6:0]        out_velocity;
	logic              out_note_on;
	logic [15:0]       bar_count;
	logic [4:0]        beat_count;
	logic [6:0]        pulse_count;

	modport source (
		output valid, found, read_value, out_channel, out_number, out_velocity,
			out_note_on, bar_count, beat_count, pulse_count,
		input ready
	);
	modport sink (
		input valid, found, read_value, out_channel, out_number, out_velocity,
			out_note_on, bar_count, beat_count, pulse_count,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/mmdcc_ram.sv =====
`default_nettype none

module mmdcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mmdcc_pkg::EVENT_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/mmdcc_ring.sv =====
`default_nettype none

module mmdcc_ring #(
	parameter int DEPTH = mmdcc_pkg::EVENT_DEPTH_DEF,
	parameter int WIDTH = $bits(mmdcc_pkg::event_entry_t)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_req,
	input  wire logic             push,
	input  wire logic             pop,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  not_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [PW-1:0] rd_q;
	logic [PW-1:0] wr_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] rd_next;
	logic [PW-1:0] wr_next;
	logic          full;

	// wrapping pointers for any depth
	assign rd_next   = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
	assign wr_next   = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);

	// push on full drops the oldest entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else if (push) begin
			wr_q <= wr_next;
			if (full) begin
				rd_q <= rd_next;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end else if (pop) begin
			rd_q  <= rd_next;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	mmdcc_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (wr_q),
		.wr_data (wr_data),
		.rd_en   (rd_req),
		.rd_addr (rd_q),
		.rd_data (rd_data)
	);

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("ring count above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CW'(DEPTH)) |-> (rd_q == wr_q))
		else $error("ring pointers disagree with count");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("pop from empty ring");
`endif

endmodule

`default_nettype wire

// ===== src/mmdcc_dp.sv =====
`default_nettype none

module mmdcc_dp #(
	parameter int NOTE_DEPTH  = mmdcc_pkg::NOTE_DEPTH_DEF,
	parameter int EVENT_DEPTH = mmdcc_pkg::EVENT_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mmdcc_pkg::cmd_t               cmd,
	output mmdcc_pkg::sts_t                    sts,
	input  wire logic [2:0]                    func,
	input  wire logic [7:0]                    status_byte,
	input  wire logic [6:0]                    data_one,
	input  wire logic [6:0]                    data_two,
	input  wire logic [1:0]                    msg_len,
	input  wire logic [3:0]                    query_channel,
	input  wire logic [6:0]                    query_controller,
	input  wire logic                          cfg_wr_en,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [mmdcc_pkg::CFG_DW-1:0]  cfg_data,
	output mmdcc_pkg::result_t                 res
);

	// configuration
	logic [1:0] mode_q;
	logic [5:0] bpb_q;
	logic [6:0] cpb_q;

	// captured request
	logic [2:0]                   func_q;
	logic [7:0]                   status_q;
	logic [6:0]                   d1_q;
	logic [6:0]                   d2_q;
	logic [1:0]                   len_q;
	logic [3:0]                   qch_q;
	logic [mmdcc_pkg::CTL_AW-1:0] qaddr_q;

	// song position
	logic [15:0] bar_q;
	logic [4:0]  beat_q;
	logic [6:0]  pulse_q;

	logic [6:0] prog_q [mmdcc_pkg::CHANNELS];
	logic [mmdcc_pkg::CTL_AW-1:0] clr_addr_q;
	mmdcc_pkg::result_t res_q;

	logic [3:0] msg_type;
	logic [3:0] msg_ch;
	logic       is_prog;
	logic       is_cc;
	logic       is_note;
	logic       is_clock;
	logic       is_start;
	logic       is_msg;
	logic       is_rd_ctl;
	logic       is_pop_note;
	logic       is_pop_event;
	logic [6:0] cc_num;
	logic [7:0] cc_val;
	logic [mmdcc_pkg::CTL_AW-1:0] cc_addr;

	logic                         ctl_we;
	logic [mmdcc_pkg::CTL_AW-1:0] ctl_waddr;
	logic [7:0]                   ctl_wdata;
	logic [7:0]                   ctl_rdata;

	mmdcc_pkg::note_entry_t  note_wr;
	mmdcc_pkg::note_entry_t  note_rd;
	mmdcc_pkg::event_entry_t event_wr;
	mmdcc_pkg::event_entry_t event_rd;
	logic [$bits(mmdcc_pkg::note_entry_t)-1:0]  note_rd_bits;
	logic [$bits(mmdcc_pkg::event_entry_t)-1:0] event_rd_bits;
	logic note_ne;
	logic event_ne;

	logic [6:0]  cpb_eff;
	logic [5:0]  bpb_eff;
	logic [6:0]  pulse_inc;
	logic [4:0]  beat_inc;
	logic [15:0] bar_nx;
	logic [4:0]  beat_nx;
	logic [6:0]  pulse_nx;
	mmdcc_pkg::result_t res_d;

	// request decode
	assign msg_type     = status_q[7:4];
	assign msg_ch       = status_q[3:0];
	assign is_msg       = (func_q == mmdcc_pkg::FUNC_MESSAGE);
	assign is_rd_ctl    = (func_q == mmdcc_pkg::FUNC_READ_CTL);
	assign is_pop_note  = (func_q == mmdcc_pkg::FUNC_POP_NOTE);
	assign is_pop_event = (func_q == mmdcc_pkg::FUNC_POP_EVENT);
	assign is_prog = is_msg && (msg_type == mmdcc_pkg::TYPE_PROG_CHANGE)
		&& (len_q == mmdcc_pkg::LEN_TWO);
	assign is_cc = is_msg && (msg_type == mmdcc_pkg::TYPE_CTL_CHANGE)
		&& (len_q == mmdcc_pkg::LEN_THREE);
	assign is_note = is_msg && (len_q == mmdcc_pkg::LEN_THREE)
		&& ((msg_type == mmdcc_pkg::TYPE_NOTE_OFF) || (msg_type == mmdcc_pkg::TYPE_NOTE_ON));
	assign is_clock = is_msg && (msg_type == mmdcc_pkg::TYPE_SYSTEM)
		&& (len_q == mmdcc_pkg::LEN_ONE) && (msg_ch == mmdcc_pkg::SYS_CLOCK);
	assign is_start = is_msg && (msg_type == mmdcc_pkg::TYPE_SYSTEM)
		&& (len_q == mmdcc_pkg::LEN_ONE) && (msg_ch == mmdcc_pkg::SYS_START);

	// control change value by encoder mode
	always_comb begin
		cc_num = d1_q;
		cc_val = {1'b0, d2_q};
		case (mode_q)
			mmdcc_pkg::MODE_REL_OFFSET: begin
				if (d2_q > mmdcc_pkg::REL_CENTER) begin
					cc_val = {1'b0, mmdcc_pkg::REL_CENTER} - {1'b0, d2_q};
				end
			end
			mmdcc_pkg::MODE_REL_INCDEC: begin
				cc_num = d2_q;
				cc_val = (d1_q == mmdcc_pkg::DEC_CODE) ? 8'hFF : 8'd1;
			end
			default: begin
			end
		endcase
	end
	assign cc_addr = {msg_ch, cc_num};

	// controller table port: clearing sweep, store, or clear on read in any mode but absolute
	always_comb begin
		ctl_we    = 1'b0;
		ctl_waddr = qaddr_q;
		ctl_wdata = '0;
		if (cmd.clr) begin
			ctl_we    = 1'b1;
			ctl_waddr = clr_addr_q;
		end else if (cmd.exec && is_cc) begin
			ctl_we    = 1'b1;
			ctl_waddr = cc_addr;
			ctl_wdata = cc_val;
		end else if (cmd.exec && is_rd_ctl && (mode_q != mmdcc_pkg::MODE_ABSOLUTE)) begin
			ctl_we = 1'b1;
		end
	end

	mmdcc_ram #(
		.WIDTH (8),
		.DEPTH (mmdcc_pkg::CTL_ENTRIES)
	) u_ctl_ram (
		.clk     (clk),
		.wr_en   (ctl_we),
		.wr_addr (ctl_waddr),
		.wr_data (ctl_wdata),
		.rd_en   (cmd.accept),
		.rd_addr ({query_channel, query_controller}),
		.rd_data (ctl_rdata)
	);

	// queued notes and events
	assign note_wr = '{note_on: (msg_type == mmdcc_pkg::TYPE_NOTE_ON), channel: msg_ch,
		number: d1_q, velocity: d2_q};
	assign event_wr = '{channel: msg_ch, number: cc_num, value: cc_val};
	assign note_rd  = mmdcc_pkg::note_entry_t'(note_rd_bits);
	assign event_rd = mmdcc_pkg::event_entry_t'(event_rd_bits);

	mmdcc_ring #(
		.DEPTH (NOTE_DEPTH),
		.WIDTH ($bits(mmdcc_pkg::note_entry_t))
	) u_note_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_req    (cmd.accept),
		.push      (cmd.exec && is_note),
		.pop       (cmd.exec && is_pop_note && note_ne),
		.wr_data   (note_wr),
		.rd_data   (note_rd_bits),
		.not_empty (note_ne)
	);

	mmdcc_ring #(
		.DEPTH (EVENT_DEPTH),
		.WIDTH ($bits(mmdcc_pkg::event_entry_t))
	) u_event_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_req    (cmd.accept),
		.push      (cmd.exec && is_cc),
		.pop       (cmd.exec && is_pop_event && event_ne),
		.wr_data   (event_wr),
		.rd_data   (event_rd_bits),
		.not_empty (event_ne)
	);

	// next song position from timing clock and start messages
	assign cpb_eff   = (cpb_q == '0) ? 7'd1 : cpb_q;
	assign pulse_inc = pulse_q + 7'd1;
	assign beat_inc  = beat_q + 5'd1;
	always_comb begin
		if (bpb_q == '0) begin
			bpb_eff = 6'd1;
		end else if (bpb_q > mmdcc_pkg::MAX_BEATS) begin
			bpb_eff = mmdcc_pkg::MAX_BEATS;
		end else begin
			bpb_eff = bpb_q;
		end
	end

	always_comb begin
		bar_nx   = bar_q;
		beat_nx  = beat_q;
		pulse_nx = pulse_q;
		if (is_start) begin
			bar_nx   = '0;
			beat_nx  = '0;
			pulse_nx = '0;
		end else if (is_clock) begin
			pulse_nx = pulse_inc;
			if (pulse_inc >= cpb_eff) begin
				pulse_nx = '0;
				beat_nx  = beat_inc;
				if (({1'b0, beat_inc} >= bpb_eff) || (beat_inc == '0)) begin
					beat_nx = '0;
					bar_nx  = bar_q + 16'd1;
				end
			end
		end
	end

	// result of the current transaction
	always_comb begin
		res_d             = '0;
		res_d.bar_count   = bar_nx;
		res_d.beat_count  = beat_nx;
		res_d.pulse_count = pulse_nx;
		case (mmdcc_pkg::func_t'(func_q))
			mmdcc_pkg::FUNC_READ_CTL: begin
				res_d.found      = 1'b1;
				res_d.read_value = ctl_rdata;
			end
			mmdcc_pkg::FUNC_READ_PROG: begin
				res_d.found      = 1'b1;
				res_d.read_value = {1'b0, prog_q[qch_q]};
			end
			mmdcc_pkg::FUNC_POP_NOTE: begin
				if (note_ne) begin
					res_d.found        = 1'b1;
					res_d.out_note_on  = note_rd.note_on;
					res_d.out_channel  = note_rd.channel;
					res_d.out_number   = note_rd.number;
					res_d.out_velocity = note_rd.velocity;
				end
			end
			mmdcc_pkg::FUNC_POP_EVENT: begin
				if (event_ne) begin
					res_d.found       = 1'b1;
					res_d.out_channel = event_rd.channel;
					res_d.out_number  = event_rd.number;
					res_d.read_value  = event_rd.value;
				end
			end
			default: begin
			end
		endcase
	end

	// capture request on accept and the result on execute
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= func;
			status_q <= status_byte;
			d1_q     <= data_one;
			d2_q     <= data_two;
			len_q    <= msg_len;
			qch_q    <= query_channel;
			qaddr_q  <= {query_channel, query_controller};
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	// configuration and song position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= mmdcc_pkg::MODE_ABSOLUTE;
			bpb_q   <= 6'd4;
			cpb_q   <= 7'd24;
			bar_q   <= '0;
			beat_q  <= '0;
			pulse_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mmdcc_pkg::REG_ENCODER_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				mmdcc_pkg::REG_BEATS_PER_BAR: begin
					bpb_q   <= cfg_data[5:0];
					bar_q   <= '0;
					beat_q  <= '0;
					pulse_q <= '0;
				end
				mmdcc_pkg::REG_CLOCKS_PER_BEAT: begin
					cpb_q   <= cfg_data;
					bar_q   <= '0;
					beat_q  <= '0;
					pulse_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.exec) begin
			bar_q   <= bar_nx;
			beat_q  <= beat_nx;
			pulse_q <= pulse_nx;
		end
	end

	// program table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mmdcc_pkg::CHANNELS; i++) begin
				prog_q[i] <= '0;
			end
		end else if (cmd.exec && is_prog) begin
			prog_q[msg_ch] <= d1_q;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + mmdcc_pkg::CTL_AW'(1);
		end
	end

	assign sts.clr_last = (clr_addr_q == '1);
	assign res          = res_q;

endmodule

`default_nettype wire

// ===== src/mmdcc_ctrl.sv =====
`default_nettype none

module mmdcc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mmdcc_pkg::cmd_t       cmd,
	input  wire mmdcc_pkg::sts_t  sts
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// commands to the datapath
	always_comb begin
		cmd.clr    = (state_q == ST_CLEAR);
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.exec   = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd.exec) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) cmd.exec |=> out_valid_q)
		else $error("result not presented after execute");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_EXEC) && !in_ready)
		else $error("accepted transaction not executed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && out_valid_q && !out_ready |-> !cmd.exec)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== src/midi_message_decoder_with_cc_store.sv =====
// a request is captured on accept; its result is registered on execute, which waits while an earlier result is pending
// no new request is accepted until the current one executes; the controller ram is read on accept, written on execute
// a finished result waits in an output register while the next request is accepted
// reset: asynchronous, active low; the controller table is then cleared by a sweep over all
// 2048 entries during which no request is accepted (configuration writes are taken)
`default_nettype none

module midi_message_decoder_with_cc_store #(
	parameter int NOTE_DEPTH  = mmdcc_pkg::NOTE_DEPTH_DEF,
	parameter int EVENT_DEPTH = mmdcc_pkg::EVENT_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	mmdcc_in_if.sink                          in_ch,
	mmdcc_out_if.source                       out_ch,
	input  wire logic                         cfg_wr_en,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [mmdcc_pkg::CFG_DW-1:0] cfg_data
);

	mmdcc_pkg::cmd_t    cmd;
	mmdcc_pkg::sts_t    sts;
	mmdcc_pkg::result_t res;

	mmdcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mmdcc_dp #(
		.NOTE_DEPTH  (NOTE_DEPTH),
		.EVENT_DEPTH (EVENT_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.func             (in_ch.func),
		.status_byte      (in_ch.status_byte),
		.data_one         (in_ch.data_one),
		.data_two         (in_ch.data_two),
		.msg_len          (in_ch.msg_len),
		.query_channel    (in_ch.query_channel),
		.query_controller (in_ch.query_controller),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.res              (res)
	);

	// result payload
	assign out_ch.found        = res.found;
	assign out_ch.read_value   = $signed(res.read_value);
	assign out_ch.out_channel  = res.out_channel;
	assign out_ch.out_number   = res.out_number;
	assign out_ch.out_velocity = res.out_velocity;
	assign out_ch.out_note_on  = res.out_note_on;
	assign out_ch.bar_count    = res.bar_count;
	assign out_ch.beat_count   = res.beat_count;
	assign out_ch.pulse_count  = res.pulse_count;

endmodule

`default_nettype wire
